/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/hrp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrp_pkg
// Types and constants shared by the request head parser modules.
// ---------------------------------------------------------------------------
package hrp_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		V_PENDING = 2'd0,
		V_DONE    = 2'd1,
		V_BAD     = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		R_NONE       = 3'd0,
		R_METHOD     = 3'd1,
		R_URI        = 3'd2,
		R_NAME_FIRST = 3'd3,
		R_NAME       = 3'd4,
		R_VALUE      = 3'd5
	} role_t;

	typedef enum logic [3:0] {
		K_OTHER,
		K_SPACE,
		K_TAB,
		K_CR,
		K_LF,
		K_COLON,
		K_DOT,
		K_SLASH,
		K_H,
		K_T,
		K_P
	} char_kind_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       restart;
	} item_t;

	typedef struct packed {
		verdict_t    verdict;
		role_t       byte_role;
		logic [15:0] major_version;
		logic [15:0] minor_version;
	} result_t;

	// Classified word passed from the front to the back.
	typedef struct packed {
		logic       restart;
		char_kind_t kind;
		logic       is_token;
		logic       is_ctl;
		logic       is_numeral;
		logic [3:0] digit;
	} cls_t;

endpackage

/* hw/rtl/http_request_head_parser.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// http_request_head_parser
// Byte-serial HTTP/1.1 request head parser with a verdict and role per byte.
// ---------------------------------------------------------------------------
//  Channel   Handshake      Payload    Direction
//  item      push / full    item_t     into the block, one byte per word
//  result    pop / empty    result_t   out of the block, one word per byte
//
// One byte is accepted and one result produced per cycle when both sides flow.
// An accepted byte is registered in a queue slot and then in the result register.
// The classifier and parser core are joined by a four-word queue, so a
// stalled result side fills the queue before full is raised.
// Asynchronous reset returns the parser to method start with zero versions.
module http_request_head_parser import hrp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	logic wr_en;
	cls_t wr_data;
	logic rd_en;
	logic rd_valid;
	cls_t rd_data;

	hrp_front u_front (
		.item    (item),
		.push    (push),
		.full    (full),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	hrp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_data  (wr_data),
		.full     (full),
		.rd_en    (rd_en),
		.rd_valid (rd_valid),
		.rd_data  (rd_data)
	);

	hrp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (rd_valid),
		.rd_data  (rd_data),
		.rd_en    (rd_en),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

/* hw/rtl/hrp_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrp_front
// Byte classifier: turns each accepted byte into a class word for the queue.
// ---------------------------------------------------------------------------
module hrp_front import hrp_pkg::*; (
	input  item_t item,
	input  logic  push,
	input  logic  full,
	output logic  wr_en,
	output cls_t  wr_data
);

	logic [7:0] b;
	logic       ctl;
	logic       sep;

	assign b = item.byte_value;

	always_comb begin
		ctl = (b <= 8'd31) || (b == 8'd127);
		case (b)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
			"/", "[", "]", "?", "=", "{", "}", " ", "\t": sep = 1'b1;
			default: sep = 1'b0;
		endcase
	end

	always_comb begin
		wr_data            = '0;
		wr_data.restart    = item.restart;
		wr_data.is_ctl     = ctl;
		wr_data.is_token   = !b[7] && !ctl && !sep;
		wr_data.is_numeral = (b >= "0") && (b <= "9");
		wr_data.digit      = 4'(b - "0");
		case (b)
			" ":     wr_data.kind = K_SPACE;
			"\t":    wr_data.kind = K_TAB;
			"\r":    wr_data.kind = K_CR;
			"\n":    wr_data.kind = K_LF;
			":":     wr_data.kind = K_COLON;
			".":     wr_data.kind = K_DOT;
			"/":     wr_data.kind = K_SLASH;
			"H":     wr_data.kind = K_H;
			"T":     wr_data.kind = K_T;
			"P":     wr_data.kind = K_P;
			default: wr_data.kind = K_OTHER;
		endcase
	end

	assign wr_en = push && !full;

endmodule

/* hw/rtl/hrp_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrp_queue
// Short queue of class words between the classifier and the parser core.
// ---------------------------------------------------------------------------
module hrp_queue import hrp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cls_t wr_data,
	output logic full,
	input  logic rd_en,
	output logic rd_valid,
	output cls_t rd_data
);

	cls_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	assign full     = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/hrp_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrp_back
// Parser core: steps the request head state machine and holds the result.
// ---------------------------------------------------------------------------
module hrp_back import hrp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    rd_valid,
	input  cls_t    rd_data,
	output logic    rd_en,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	typedef enum logic [4:0] {
		S_METHOD_START,
		S_METHOD,
		S_URI,
		S_VER_H,
		S_VER_T1,
		S_VER_T2,
		S_VER_P,
		S_VER_SLASH,
		S_MAJOR_START,
		S_MAJOR,
		S_MINOR_START,
		S_MINOR,
		S_NL1,
		S_LINE_START,
		S_LWS,
		S_NAME,
		S_SPACE_BEFORE_VALUE,
		S_VALUE,
		S_NL2,
		S_NL3
	} state_t;

	state_t      state_q;
	logic [15:0] major_q;
	logic [15:0] minor_q;
	logic        seen_q;
	logic        out_valid_q;
	result_t     out_q;

	state_t      st;
	state_t      nst;
	logic [15:0] maj;
	logic [15:0] mnr;
	logic        seen;
	logic [15:0] nmaj;
	logic [15:0] nmnr;
	logic        nseen;
	logic [15:0] maj_dig;
	logic [15:0] mnr_dig;
	verdict_t    verdict;
	role_t       role;
	cls_t        c;
	logic        lws;

	function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [3:0] d);
		logic [19:0] sum;
		sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d};
		return (sum[19:16] != 4'd0) ? 16'hFFFF : sum[15:0];
	endfunction

	assign c       = rd_data;
	assign rd_en   = rd_valid && (!out_valid_q || pop);
	assign empty   = !out_valid_q;
	assign result  = out_q;
	assign maj_dig = add_digit(maj, c.digit);
	assign mnr_dig = add_digit(mnr, c.digit);
	assign lws     = (c.kind == K_SPACE) || (c.kind == K_TAB);

	always_comb begin
		st      = c.restart ? S_METHOD_START : state_q;
		maj     = c.restart ? 16'd0 : major_q;
		mnr     = c.restart ? 16'd0 : minor_q;
		seen    = c.restart ? 1'b0 : seen_q;
		nst     = st;
		nmaj    = maj;
		nmnr    = mnr;
		nseen   = seen;
		verdict = V_PENDING;
		role    = R_NONE;
		case (st)
			S_METHOD_START: begin
				if (c.is_token) begin
					nst  = S_METHOD;
					role = R_METHOD;
				end else verdict = V_BAD;
			end
			S_METHOD: begin
				if (c.kind == K_SPACE) nst = S_URI;
				else if (c.is_token) role = R_METHOD;
				else verdict = V_BAD;
			end
			S_URI: begin
				if (c.kind == K_SPACE) nst = S_VER_H;
				else if (c.is_ctl) verdict = V_BAD;
				else role = R_URI;
			end
			S_VER_H: begin
				if (c.kind == K_H) nst = S_VER_T1; else verdict = V_BAD;
			end
			S_VER_T1: begin
				if (c.kind == K_T) nst = S_VER_T2; else verdict = V_BAD;
			end
			S_VER_T2: begin
				if (c.kind == K_T) nst = S_VER_P; else verdict = V_BAD;
			end
			S_VER_P: begin
				if (c.kind == K_P) nst = S_VER_SLASH; else verdict = V_BAD;
			end
			S_VER_SLASH: begin
				if (c.kind == K_SLASH) begin
					nmaj = 16'd0;
					nmnr = 16'd0;
					nst  = S_MAJOR_START;
				end else verdict = V_BAD;
			end
			S_MAJOR_START: begin
				if (c.is_numeral) begin
					nmaj = maj_dig;
					nst  = S_MAJOR;
				end else verdict = V_BAD;
			end
			S_MAJOR: begin
				if (c.kind == K_DOT) nst = S_MINOR_START;
				else if (c.is_numeral) nmaj = maj_dig;
				else verdict = V_BAD;
			end
			S_MINOR_START: begin
				if (c.is_numeral) begin
					nmnr = mnr_dig;
					nst  = S_MINOR;
				end else verdict = V_BAD;
			end
			S_MINOR: begin
				if (c.kind == K_CR) nst = S_NL1;
				else if (c.is_numeral) nmnr = mnr_dig;
				else verdict = V_BAD;
			end
			S_NL1: begin
				if (c.kind == K_LF) nst = S_LINE_START; else verdict = V_BAD;
			end
			S_LINE_START: begin
				if (c.kind == K_CR) nst = S_NL3;
				else if (seen && lws) nst = S_LWS;
				else if (c.is_token) begin
					nseen = 1'b1;
					nst   = S_NAME;
					role  = R_NAME_FIRST;
				end else verdict = V_BAD;
			end
			S_LWS: begin
				if (c.kind == K_CR) nst = S_NL2;
				else if (lws) nst = S_LWS;
				else if (c.is_ctl) verdict = V_BAD;
				else begin
					nst  = S_VALUE;
					role = R_VALUE;
				end
			end
			S_NAME: begin
				if (c.kind == K_COLON) nst = S_SPACE_BEFORE_VALUE;
				else if (c.is_token) role = R_NAME;
				else verdict = V_BAD;
			end
			S_SPACE_BEFORE_VALUE: begin
				if (c.kind == K_SPACE) nst = S_VALUE; else verdict = V_BAD;
			end
			S_VALUE: begin
				if (c.kind == K_CR) nst = S_NL2;
				else if (c.is_ctl) verdict = V_BAD;
				else role = R_VALUE;
			end
			S_NL2: begin
				if (c.kind == K_LF) nst = S_LINE_START; else verdict = V_BAD;
			end
			S_NL3: begin
				if (c.kind == K_LF) verdict = V_DONE; else verdict = V_BAD;
			end
			default: verdict = V_BAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_METHOD_START;
			major_q     <= '0;
			minor_q     <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (rd_en) begin
				state_q             <= nst;
				major_q             <= nmaj;
				minor_q             <= nmnr;
				seen_q              <= nseen;
				out_valid_q         <= 1'b1;
				out_q.verdict       <= verdict;
				out_q.byte_role     <= role;
				out_q.major_version <= nmaj;
				out_q.minor_version <= nmnr;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/hrp_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrp_checker
// Port-level checks on the request head parser, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hrp_checker import hrp_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    full,
	input logic    pop,
	input logic    empty,
	input result_t result
);

	`ASSERT_IMPL(a_role_only_pending, clk, arst_n, !empty && (result.byte_role != R_NONE), result.verdict == V_PENDING, "role tag on a byte that is not pending")

	`ASSERT_NEXT(a_result_held, clk, arst_n, !empty && !pop, !empty && $stable(result), "waiting result word changed or vanished")

	`ASSERT_NEXT(a_full_while_stalled, clk, arst_n, full && !empty && !pop, full, "queue drained while the result word was held")

endmodule

bind http_request_head_parser hrp_checker u_checker (.*);

/* test/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for http_request_head_parser. Request heads with random
// content, some with stray or missing bytes, are sent one byte per word, and
// each result word is compared against a parser state machine kept in the
// bench, under random idling on both sides and a long result-side stall.
// ---------------------------------------------------------------------------
module tb;
	import hrp_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int TOTAL_ITEMS  = 1750;

	typedef enum logic [4:0] {
		P_METHOD_START, P_METHOD, P_URI, P_H, P_T1, P_T2, P_P, P_SLASH,
		P_MAJOR_START, P_MAJOR, P_MINOR_START, P_MINOR, P_LF1, P_LINE_START,
		P_FOLD, P_NAME, P_COLON_SPACE, P_VALUE, P_LF2, P_LF_END
	} parse_state_t;

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    pop;
	logic    empty;
	result_t result;

	parse_state_t pstate;
	logic [15:0]  major_acc;
	logic [15:0]  minor_acc;
	logic         header_seen;

	result_t byte_verdicts_due[$];
	int      mismatches;
	int      bytes_sent;
	int      words_checked;
	int      rx_hold;
	bit      idling;

	http_request_head_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit is_ctl(input logic [7:0] b);
		return b <= 8'd31 || b == 8'd127;
	endfunction

	function automatic bit is_sep(input logic [7:0] b);
		case (b)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
			"/", "[", "]", "?", "=", "{", "}", " ", "\t": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit is_token(input logic [7:0] b);
		return b <= 8'd127 && !is_ctl(b) && !is_sep(b);
	endfunction

	function automatic bit is_dec_char(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] b);
		int v;
		v = int'(acc) * 10 + int'(b) - int'("0");
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic result_t parse_byte(input logic [7:0] b, input logic rs);
		result_t r;
		parse_state_t nxt;
		r.verdict   = V_PENDING;
		r.byte_role = R_NONE;
		nxt = pstate;
		if (rs) begin
			nxt         = P_METHOD_START;
			major_acc   = '0;
			minor_acc   = '0;
			header_seen = 1'b0;
		end
		case (nxt)
			P_METHOD_START: begin
				if (is_token(b)) begin
					nxt = P_METHOD;
					r.byte_role = R_METHOD;
				end else r.verdict = V_BAD;
			end
			P_METHOD: begin
				if (b == " ") nxt = P_URI;
				else if (is_token(b)) r.byte_role = R_METHOD;
				else r.verdict = V_BAD;
			end
			P_URI: begin
				if (b == " ") nxt = P_H;
				else if (is_ctl(b)) r.verdict = V_BAD;
				else r.byte_role = R_URI;
			end
			P_H: if (b == "H") nxt = P_T1; else r.verdict = V_BAD;
			P_T1: if (b == "T") nxt = P_T2; else r.verdict = V_BAD;
			P_T2: if (b == "T") nxt = P_P; else r.verdict = V_BAD;
			P_P: if (b == "P") nxt = P_SLASH; else r.verdict = V_BAD;
			P_SLASH: begin
				if (b == "/") begin
					major_acc = '0;
					minor_acc = '0;
					nxt = P_MAJOR_START;
				end else r.verdict = V_BAD;
			end
			P_MAJOR_START: begin
				if (is_dec_char(b)) begin
					major_acc = add_digit(major_acc, b);
					nxt = P_MAJOR;
				end else r.verdict = V_BAD;
			end
			P_MAJOR: begin
				if (b == ".") nxt = P_MINOR_START;
				else if (is_dec_char(b)) major_acc = add_digit(major_acc, b);
				else r.verdict = V_BAD;
			end
			P_MINOR_START: begin
				if (is_dec_char(b)) begin
					minor_acc = add_digit(minor_acc, b);
					nxt = P_MINOR;
				end else r.verdict = V_BAD;
			end
			P_MINOR: begin
				if (b == "\r") nxt = P_LF1;
				else if (is_dec_char(b)) minor_acc = add_digit(minor_acc, b);
				else r.verdict = V_BAD;
			end
			P_LF1: if (b == "\n") nxt = P_LINE_START; else r.verdict = V_BAD;
			P_LINE_START: begin
				if (b == "\r") nxt = P_LF_END;
				else if (header_seen && (b == " " || b == "\t")) nxt = P_FOLD;
				else if (is_token(b)) begin
					header_seen = 1'b1;
					nxt = P_NAME;
					r.byte_role = R_NAME_FIRST;
				end else r.verdict = V_BAD;
			end
			P_FOLD: begin
				if (b == "\r") nxt = P_LF2;
				else if (b == " " || b == "\t") nxt = P_FOLD;
				else if (is_ctl(b)) r.verdict = V_BAD;
				else begin
					nxt = P_VALUE;
					r.byte_role = R_VALUE;
				end
			end
			P_NAME: begin
				if (b == ":") nxt = P_COLON_SPACE;
				else if (is_token(b)) r.byte_role = R_NAME;
				else r.verdict = V_BAD;
			end
			P_COLON_SPACE: if (b == " ") nxt = P_VALUE; else r.verdict = V_BAD;
			P_VALUE: begin
				if (b == "\r") nxt = P_LF2;
				else if (is_ctl(b)) r.verdict = V_BAD;
				else r.byte_role = R_VALUE;
			end
			P_LF2: if (b == "\n") nxt = P_LINE_START; else r.verdict = V_BAD;
			P_LF_END: if (b == "\n") r.verdict = V_DONE; else r.verdict = V_BAD;
			default: r.verdict = V_BAD;
		endcase
		pstate = nxt;
		r.major_version = major_acc;
		r.minor_version = minor_acc;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at result word %0d: %s", words_checked, what);
		mismatches++;
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (byte_verdicts_due.size() == 0) begin
			report_mismatch("result word with no byte outstanding");
			return;
		end
		want = byte_verdicts_due.pop_front();
		if (got.verdict !== want.verdict)
			report_mismatch($sformatf("verdict %0d, predicted %0d", got.verdict, want.verdict));
		if (got.byte_role !== want.byte_role)
			report_mismatch($sformatf("role %0d, predicted %0d", got.byte_role, want.byte_role));
		if (got.major_version !== want.major_version)
			report_mismatch($sformatf("major %0d, predicted %0d",
				got.major_version, want.major_version));
		if (got.minor_version !== want.minor_version)
			report_mismatch($sformatf("minor %0d, predicted %0d",
				got.minor_version, want.minor_version));
		words_checked++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic rs);
		if (idling && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		push <= 1'b1;
		item <= '{byte_value: b, restart: rs};
		do @(posedge clk); while (full);
		byte_verdicts_due = {byte_verdicts_due, parse_byte(b, rs)};
		bytes_sent++;
	endtask

	task automatic wait_drain;
		push <= 1'b0;
		do @(posedge clk); while (byte_verdicts_due.size() != 0);
	endtask

	task automatic emit(input logic [7:0] b, input logic rs, input bit noisy);
		if (noisy && $urandom_range(0, 24) == 0)
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
		if (!(noisy && $urandom_range(0, 39) == 0))
			send_byte(b, rs);
	endtask

	task automatic emit_text(input string s, input bit noisy);
		for (int i = 0; i < s.len(); i++)
			emit(s[i], 1'b0, noisy);
	endtask

	function automatic logic [7:0] rand_token;
		logic [7:0] b;
		do b = 8'($urandom_range(33, 126)); while (!is_token(b));
		return b;
	endfunction

	function automatic logic [7:0] rand_text(input bit allow_space);
		logic [7:0] b;
		do b = 8'($urandom_range(allow_space ? 32 : 33, 255)); while (b == 8'd127);
		return b;
	endfunction

	task automatic emit_number(input bit noisy);
		int n;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 7) : $urandom_range(1, 2);
		repeat (n) emit(8'("0" + $urandom_range(0, 9)), 1'b0, noisy);
	endtask

	task automatic send_head(input bit noisy, input int headers);
		emit(rand_token(), $urandom_range(0, 7) != 0, noisy);
		repeat ($urandom_range(0, 5)) emit(rand_token(), 1'b0, noisy);
		emit_text(" ", noisy);
		repeat ($urandom_range(1, 8)) emit(rand_text(1'b0), 1'b0, noisy);
		emit_text(" HTTP/", noisy);
		emit_number(noisy);
		emit_text(".", noisy);
		emit_number(noisy);
		emit_text("\r\n", noisy);
		repeat (headers) begin
			emit(rand_token(), 1'b0, noisy);
			repeat ($urandom_range(0, 5)) emit(rand_token(), 1'b0, noisy);
			emit_text(": ", noisy);
			repeat ($urandom_range(0, 6)) emit(rand_text(1'b1), 1'b0, noisy);
			emit_text("\r\n", noisy);
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 2)) emit($urandom_range(0, 1) ? " " : "\t", 1'b0, noisy);
				repeat ($urandom_range(0, 4)) emit(rand_text(1'b1), 1'b0, noisy);
				emit_text("\r\n", noisy);
			end
		end
		emit_text("\r\n", noisy);
		if ($urandom_range(0, 3) == 0) emit_text("\n", noisy);
	endtask

	task automatic test_rejected_bytes;
		send_byte(8'h00, 1'b1);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(" ", 1'b0);
	endtask

	task automatic test_directed_head;
		send_byte("G", 1'b1);
		send_byte(" ", 1'b0);
		send_byte(8'hFF, 1'b0);
		emit_text(" HTTP/99999.1\r\n", 1'b0);
		send_byte("\t", 1'b0);
		emit_text("X: ", 1'b0);
		send_byte(8'h80, 1'b0);
		emit_text("\r\n\t\r\n\r\n\n", 1'b0);
		send_byte("Z", 1'b0);
	endtask

	task automatic test_backpressure;
		rx_hold = 300;
		send_head(1'b0, 2);
		send_head(1'b0, 1);
	endtask

	task automatic test_drain_pause;
		wait_drain();
		send_head(1'b0, 1);
		wait_drain();
	endtask

	task automatic test_random_heads;
		idling = 1'b1;
		while (bytes_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 8))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			else
				send_head($urandom_range(0, 2) == 0, $urandom_range(0, 3));
		end
	endtask

	task automatic test_steady_flow;
		idling = 1'b0;
		while (bytes_sent < TOTAL_ITEMS)
			send_head($urandom_range(0, 3) == 0, $urandom_range(0, 3));
	endtask

	initial begin : result_side
		int stall_left;
		stall_left = 0;
		pop        = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) check_result(result);
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (idling && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 16);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		push          = 1'b0;
		item          = '0;
		idling        = 1'b0;
		rx_hold       = 0;
		mismatches    = 0;
		bytes_sent    = 0;
		words_checked = 0;
		pstate        = P_METHOD_START;
		major_acc     = '0;
		minor_acc     = '0;
		header_seen   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rejected_bytes();
		test_directed_head();
		test_backpressure();
		test_drain_pause();
		test_random_heads();
		test_steady_flow();
		wait_drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* http_request_head_parser.f */
+incdir+hw/rtl
hw/rtl/hrp_pkg.sv
hw/rtl/hrp_front.sv
hw/rtl/hrp_queue.sv
hw/rtl/hrp_back.sv
hw/rtl/http_request_head_parser.sv
hw/rtl/hrp_checker.sv
test/tb.sv
